@@ design/twrp_pkg.sv @@
// ----------------------------------------------------------------------------
// twrp_pkg
// Types and constants shared by the radix-40 word packing tokenizer.
// ----------------------------------------------------------------------------
package twrp_pkg;

    localparam int CharWidth  = 8;
    localparam int HalfWidth  = 20;
    localparam int CountWidth = 5;
    localparam int IndexWidth = 2;

    // Character codes used for classification.
    localparam logic [CharWidth-1:0] CharA      = 8'h41;
    localparam logic [CharWidth-1:0] CharZ      = 8'h5A;
    localparam logic [CharWidth-1:0] CharOne    = 8'h31;
    localparam logic [CharWidth-1:0] CharNine   = 8'h39;
    localparam logic [CharWidth-1:0] CharHyphen = 8'h2D;
    localparam logic [CharWidth-1:0] CharSpace  = 8'h20;
    localparam logic [CharWidth-1:0] CharPeriod = 8'h2E;
    localparam logic [CharWidth-1:0] CharComma  = 8'h2C;

    localparam logic [CharWidth-1:0] BaseReset = 8'd120;

    // Packing weights for the three positions of a half.
    localparam logic [HalfWidth-1:0] WeightHigh = 20'd1600;
    localparam logic [HalfWidth-1:0] WeightMid  = 20'd40;
    localparam logic [HalfWidth-1:0] WeightLow  = 20'd1;

    localparam logic [2:0] WordChars = 3'd6;
    localparam logic [2:0] HalfChars = 3'd3;

    localparam logic [CountWidth-1:0] MaxWords = 5'd20;

    typedef enum logic [IndexWidth-1:0] {
        REG_LETTER_BASE = 2'd0,
        REG_DIGIT_BASE  = 2'd1,
        REG_HYPHEN_BASE = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        KIND_WORD     = 3'd0,
        KIND_OK       = 3'd1,
        KIND_EMPTY    = 3'd2,
        KIND_BAD      = 3'd3,
        KIND_TOO_MANY = 3'd4
    } kind_t;

    // One queued job: an optional word result followed by an optional status.
    typedef struct packed {
        logic                         has_word;
        logic signed [HalfWidth-1:0]  first_half;
        logic signed [HalfWidth-1:0]  second_half;
        logic [CountWidth-1:0]        word_count;
        logic                         has_status;
        kind_t                        status_kind;
        logic [CountWidth-1:0]        status_count;
    } job_t;

    // Head of the job queue as seen by the back end.
    typedef struct packed {
        logic  empty;
        job_t  job;
    } queue_head_t;

endpackage

@@ design/twrp_if.sv @@
// ----------------------------------------------------------------------------
// twrp_if
// Valid/ready channel interfaces for characters, results and configuration.
// ----------------------------------------------------------------------------
interface twrp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_of_line;

    modport source (output valid, output character, output last_of_line, input ready);
    modport sink (input valid, input character, input last_of_line, output ready);
endinterface

interface twrp_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [19:0] first_half;
    logic signed [19:0] second_half;
    logic [4:0]         word_count;
    logic               last_result;

    modport source (output valid, output kind, output first_half, output second_half,
                    output word_count, output last_result, input ready);
    modport sink (input valid, input kind, input first_half, input second_half,
                  input word_count, input last_result, output ready);
endinterface

interface twrp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/word_tokenizer_radix40_packer_core.sv @@
// ----------------------------------------------------------------------------
// word_tokenizer_radix40_packer_core
// Radix-40 word packing tokenizer: front end, job queue and result back end.
// ----------------------------------------------------------------------------
// A character's results are registered in the job queue before being offered.
// Throughput: one character per cycle while the queue is not full; a character
// that causes two results offers them in turn, and the QUEUE_DEPTH-entry job
// queue absorbs such bursts. Reset clears all word and command state, empties
// the queue and sets every class base to 120; no clearing pass is needed.
module word_tokenizer_radix40_packer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    twrp_cfg_if.sink        cfg,
    twrp_char_if.sink       chars,
    twrp_result_if.source   results
);
    import twrp_pkg::*;

    logic         push;
    logic         pop;
    logic         full;
    job_t         job;
    queue_head_t  head;

    twrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .chars      (chars),
        .queue_full (full),
        .push       (push),
        .job        (job)
    );

    twrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .job   (job),
        .pop   (pop),
        .full  (full),
        .head  (head)
    );

    twrp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

@@ design/twrp_front.sv @@
// ----------------------------------------------------------------------------
// twrp_front
// Accepts characters, classifies them, packs word codes and builds jobs.
// ----------------------------------------------------------------------------
module twrp_front (
    input  logic          clk,
    input  logic          rst_n,
    twrp_cfg_if.sink      cfg,
    twrp_char_if.sink     chars,
    input  logic          queue_full,
    output logic          push,
    output twrp_pkg::job_t job
);
    import twrp_pkg::*;

    logic [CharWidth-1:0]         letter_base_reg;
    logic [CharWidth-1:0]         digit_base_reg;
    logic [CharWidth-1:0]         hyphen_base_reg;

    logic [2:0]                   chars_reg, chars_next;
    logic signed [HalfWidth-1:0]  first_acc_reg, first_acc_next;
    logic signed [HalfWidth-1:0]  second_acc_reg, second_acc_next;
    logic [CountWidth-1:0]        words_reg, words_next;
    logic                         discard_reg, discard_next;
    logic                         ovf_reg, ovf_next;

    logic                         accept;
    logic                         active;
    logic [CharWidth-1:0]         ch;
    logic                         last;
    logic                         is_letter, is_digit, is_hyphen, is_legal;
    logic                         is_punct, is_space, is_bad;
    logic [CharWidth-1:0]         base_sel;
    logic [CharWidth:0]           code;
    logic [HalfWidth-1:0]         code_ext;
    logic [HalfWidth-1:0]         weight;
    logic signed [HalfWidth-1:0]  product;
    logic                         add_ok;
    logic [2:0]                   chars_upd;
    logic signed [HalfWidth-1:0]  first_upd, second_upd;
    logic                         end_cmd, word_end, pending;
    logic                         word_out, word_drop;
    logic [CountWidth-1:0]        words_after;
    logic                         ovf_after;

    assign cfg.ready   = 1'b1;
    assign chars.ready = !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letter_base_reg <= BaseReset;
            digit_base_reg  <= BaseReset;
            hyphen_base_reg <= BaseReset;
        end
        else if (cfg.valid)
        begin
            case (reg_index_t'(cfg.index))
                REG_LETTER_BASE: letter_base_reg <= cfg.data;
                REG_DIGIT_BASE:  digit_base_reg  <= cfg.data;
                REG_HYPHEN_BASE: hyphen_base_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    assign accept = chars.valid && chars.ready;
    assign active = accept && !discard_reg;
    assign ch     = chars.character;
    assign last   = chars.last_of_line;

    assign is_letter = (ch >= CharA) && (ch <= CharZ);
    assign is_digit  = (ch >= CharOne) && (ch <= CharNine);
    assign is_hyphen = (ch == CharHyphen);
    assign is_legal  = is_letter || is_digit || is_hyphen;
    assign is_punct  = (ch == CharPeriod) || (ch == CharComma);
    assign is_space  = (ch == CharSpace);
    assign is_bad    = !is_legal && !is_punct && !is_space;

    always_comb
    begin
        if (is_letter)
            base_sel = letter_base_reg;
        else if (is_hyphen)
            base_sel = hyphen_base_reg;
        else
            base_sel = digit_base_reg;
    end

    // The code is a 9-bit two's complement value, possibly negative.
    assign code     = {1'b0, ch} - {1'b0, base_sel};
    assign code_ext = {{(HalfWidth-CharWidth-1){code[CharWidth]}}, code};

    always_comb
    begin
        case (chars_reg)
            3'd0, 3'd3: weight = WeightHigh;
            3'd1, 3'd4: weight = WeightMid;
            default:    weight = WeightLow;
        endcase
    end

    assign product = signed'(code_ext * weight);

    assign add_ok     = is_legal && (chars_reg < WordChars);
    assign chars_upd  = add_ok ? chars_reg + 3'd1 : chars_reg;
    assign first_upd  = (add_ok && chars_reg < HalfChars) ? first_acc_reg + product
                                                          : first_acc_reg;
    assign second_upd = (add_ok && chars_reg >= HalfChars) ? second_acc_reg + product
                                                           : second_acc_reg;

    assign end_cmd     = (is_punct || last) && !is_bad;
    assign word_end    = is_space || end_cmd;
    assign pending     = (chars_upd != 3'd0);
    assign word_out    = word_end && pending && (words_reg < MaxWords);
    assign word_drop   = word_end && pending && (words_reg >= MaxWords);
    assign words_after = words_reg + CountWidth'(word_out);
    assign ovf_after   = ovf_reg || word_drop;

    always_comb
    begin
        job.has_word     = word_out;
        job.first_half   = first_upd;
        job.second_half  = second_upd;
        job.word_count   = words_after;
        job.has_status   = end_cmd || is_bad;
        job.status_count = is_bad ? '0 : words_after;
        if (is_bad)
            job.status_kind = KIND_BAD;
        else if (ovf_after)
            job.status_kind = KIND_TOO_MANY;
        else if (words_after == '0)
            job.status_kind = KIND_EMPTY;
        else
            job.status_kind = KIND_OK;
    end

    assign push = active && (word_out || end_cmd || is_bad);

    always_comb
    begin
        chars_next      = chars_reg;
        first_acc_next  = first_acc_reg;
        second_acc_next = second_acc_reg;
        words_next      = words_reg;
        discard_next    = discard_reg;
        ovf_next        = ovf_reg;
        if (accept && discard_reg)
        begin
            if (last)
                discard_next = 1'b0;
        end
        else if (active)
        begin
            if (is_bad || end_cmd)
            begin
                chars_next      = '0;
                first_acc_next  = '0;
                second_acc_next = '0;
                words_next      = '0;
                ovf_next        = 1'b0;
                discard_next    = is_bad && !last;
            end
            else if (is_space)
            begin
                if (pending)
                begin
                    chars_next      = '0;
                    first_acc_next  = '0;
                    second_acc_next = '0;
                    words_next      = words_after;
                    ovf_next        = ovf_after;
                end
            end
            else
            begin
                chars_next      = chars_upd;
                first_acc_next  = first_upd;
                second_acc_next = second_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_reg      <= '0;
            first_acc_reg  <= '0;
            second_acc_reg <= '0;
            words_reg      <= '0;
            discard_reg    <= 1'b0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            chars_reg      <= chars_next;
            first_acc_reg  <= first_acc_next;
            second_acc_reg <= second_acc_next;
            words_reg      <= words_next;
            discard_reg    <= discard_next;
            ovf_reg        <= ovf_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && discard_reg) |-> !push)
        else $error("front produced a job while discarding a line");
    assert property (@(posedge clk) disable iff (!rst_n)
        chars_reg <= WordChars)
        else $error("word character count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        words_reg <= MaxWords)
        else $error("word count exceeds the command limit");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && job.has_status) |=> (chars_reg == '0 && words_reg == '0 && !ovf_reg))
        else $error("command state not cleared after a status job");
`endif

endmodule

@@ design/twrp_queue.sv @@
// ----------------------------------------------------------------------------
// twrp_queue
// Short job queue that decouples the character front end from the result side.
// ----------------------------------------------------------------------------
module twrp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  twrp_pkg::job_t          job,
    input  logic                    pop,
    output logic                    full,
    output twrp_pkg::queue_head_t   head
);
    import twrp_pkg::*;

    localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(DEPTH - 1);
    localparam logic [CountWidth-1:0] DepthFull = CountWidth'(DEPTH);

    job_t                   jobs_reg [DEPTH];
    logic [PtrWidth-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CountWidth-1:0]  count_reg, count_next;
    logic                   do_push, do_pop;

    assign full       = (count_reg == DepthFull);
    assign head.empty = (count_reg == '0);
    assign head.job   = jobs_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && !head.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrWidth'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrWidth'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CountWidth'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CountWidth'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            jobs_reg[wr_ptr_reg] <= job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DepthFull)
        else $error("job queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CountWidth'(1)))
        else $error("job queue count did not track a push");
`endif

endmodule

@@ design/twrp_back.sv @@
// ----------------------------------------------------------------------------
// twrp_back
// Unpacks queued jobs into word and status results, one per request.
// ----------------------------------------------------------------------------
module twrp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  twrp_pkg::queue_head_t   head,
    output logic                    pop,
    twrp_result_if.source           results
);
    import twrp_pkg::*;

    // Set once the word result of the head job is gone and its status is next.
    logic  status_phase_reg, status_phase_next;
    logic  show_word;
    logic  is_last;
    logic  take;

    assign show_word = head.job.has_word && !status_phase_reg;
    assign is_last   = !show_word || !head.job.has_status;

    assign results.valid       = !head.empty;
    assign results.kind        = show_word ? KIND_WORD : head.job.status_kind;
    assign results.first_half  = show_word ? head.job.first_half : '0;
    assign results.second_half = show_word ? head.job.second_half : '0;
    assign results.word_count  = show_word ? head.job.word_count : head.job.status_count;
    assign results.last_result = is_last;

    assign take = results.valid && results.ready;
    assign pop  = take && is_last;

    always_comb
    begin
        status_phase_next = status_phase_reg;
        if (take)
            status_phase_next = !is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            status_phase_reg <= 1'b0;
        else
            status_phase_reg <= status_phase_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        status_phase_reg |-> (!head.empty && head.job.has_word && head.job.has_status))
        else $error("status phase set without a pending two-result job");
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !is_last) |=> status_phase_reg)
        else $error("word result taken but status not next");
    assert property (@(posedge clk) disable iff (!rst_n)
        status_phase_reg |-> !show_word)
        else $error("word result shown twice");
`endif

endmodule

@@ tb/sv/tb_word_tokenizer_radix40_packer_core.sv @@
// ----------------------------------------------------------------------------
// tb_word_tokenizer_radix40_packer_core
// Self-checking testbench for the radix-40 word packing tokenizer. Character
// requests are driven as short directed lines and then as random lines that
// are mostly well-formed commands with some noise. Every accepted character
// goes through a scoreboard that predicts the word and status tokens, and
// every result token is checked against the oldest prediction. The class
// bases are changed between phases, and the phases cycle through four mixes
// of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_word_tokenizer_radix40_packer_core;
    import twrp_pkg::*;

    localparam int HalfPeriod  = 6;
    localparam int ResetCycles = 7;
    localparam int PhaseCount  = 8;
    localparam int PhaseChars  = 100;
    localparam int SettleCycles = 8;
    localparam int StallLimit  = 4000;
    localparam int ReportLimit = 10;

    // The configuration port has a fourth index that maps to no register.
    localparam logic [IndexWidth-1:0] RegSpare = 2'd3;

    typedef struct packed {
        kind_t                       kind;
        logic signed [HalfWidth-1:0] first_half;
        logic signed [HalfWidth-1:0] second_half;
        logic [CountWidth-1:0]       word_count;
        logic                        last_result;
    } token_t;

    class tokenizer_scoreboard;
        logic [CharWidth-1:0] letter_base;
        logic [CharWidth-1:0] digit_base;
        logic [CharWidth-1:0] hyphen_base;
        int     chars_in_word;
        int     first_acc;
        int     second_acc;
        int     words_in_cmd;
        bit     discarding;
        bit     overflowed;
        token_t expected_q[$];
        int     failures;

        function new();
            letter_base = BaseReset;
            digit_base  = BaseReset;
            hyphen_base = BaseReset;
            discarding  = 1'b0;
            failures    = 0;
            clear_command();
        endfunction

        function void clear_command();
            chars_in_word = 0;
            first_acc     = 0;
            second_acc    = 0;
            words_in_cmd  = 0;
            overflowed    = 1'b0;
        endfunction

        function void write_reg(logic [IndexWidth-1:0] idx, logic [CharWidth-1:0] val);
            case (idx)
                REG_LETTER_BASE: letter_base = val;
                REG_DIGIT_BASE:  digit_base  = val;
                REG_HYPHEN_BASE: hyphen_base = val;
                default: ;
            endcase
        endfunction

        function void push_token(kind_t k, int a, int b);
            token_t t;
            t.kind        = k;
            t.first_half  = a[HalfWidth-1:0];
            t.second_half = b[HalfWidth-1:0];
            t.word_count  = words_in_cmd[CountWidth-1:0];
            t.last_result = 1'b0;
            expected_q.push_back(t);
        endfunction

        // A pending word is emitted unless the command already holds the
        // maximum number of words, in which case the command is marked.
        function void close_word();
            if (chars_in_word == 0)
                return;
            if (words_in_cmd < int'(MaxWords))
            begin
                words_in_cmd++;
                push_token(KIND_WORD, first_acc, second_acc);
            end
            else
            begin
                overflowed = 1'b1;
            end
            chars_in_word = 0;
            first_acc     = 0;
            second_acc    = 0;
        endfunction

        function void note_char(logic [CharWidth-1:0] ch, logic last);
            int     code;
            int     weight;
            int     produced;
            bit     end_cmd;
            token_t t;
            produced = expected_q.size();
            end_cmd  = last;
            if (discarding)
            begin
                if (last)
                    discarding = 1'b0;
                return;
            end
            if (ch == CharPeriod || ch == CharComma)
            begin
                end_cmd = 1'b1;
            end
            else if (ch == CharSpace)
            begin
                close_word();
            end
            else if ((ch >= CharA && ch <= CharZ) || (ch >= CharOne && ch <= CharNine) ||
                     ch == CharHyphen)
            begin
                if (ch >= CharA && ch <= CharZ)
                    code = int'(ch) - int'(letter_base);
                else if (ch == CharHyphen)
                    code = int'(ch) - int'(hyphen_base);
                else
                    code = int'(ch) - int'(digit_base);
                if (chars_in_word < int'(WordChars))
                begin
                    case (chars_in_word % int'(HalfChars))
                        0:       weight = int'(WeightHigh);
                        1:       weight = int'(WeightMid);
                        default: weight = int'(WeightLow);
                    endcase
                    if (chars_in_word < int'(HalfChars))
                        first_acc += code * weight;
                    else
                        second_acc += code * weight;
                    chars_in_word++;
                end
            end
            else
            begin
                clear_command();
                push_token(KIND_BAD, 0, 0);
                discarding = !last;
                end_cmd    = 1'b0;
            end
            if (end_cmd)
            begin
                close_word();
                if (overflowed)
                    push_token(KIND_TOO_MANY, 0, 0);
                else if (words_in_cmd == 0)
                    push_token(KIND_EMPTY, 0, 0);
                else
                    push_token(KIND_OK, 0, 0);
                clear_command();
            end
            if (expected_q.size() > produced)
            begin
                t = expected_q.pop_back();
                t.last_result = 1'b1;
                expected_q.push_back(t);
            end
        endfunction

        function void check_result(token_t got);
            token_t exp;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= ReportLimit)
                    $display("unexpected token: kind %0d first %0d second %0d count %0d",
                             got.kind, got.first_half, got.second_half, got.word_count,
                             " last %0b", got.last_result);
                return;
            end
            exp = expected_q.pop_front();
            if (got.kind !== exp.kind || got.first_half !== exp.first_half ||
                got.second_half !== exp.second_half || got.word_count !== exp.word_count ||
                got.last_result !== exp.last_result)
            begin
                failures++;
                if (failures <= ReportLimit)
                begin
                    $display("token mismatch: expected kind %0d first %0d second %0d",
                             exp.kind, exp.first_half, exp.second_half,
                             " count %0d last %0b", exp.word_count, exp.last_result);
                    $display("                got      kind %0d first %0d second %0d",
                             got.kind, got.first_half, got.second_half,
                             " count %0d last %0b", got.word_count, got.last_result);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    twrp_cfg_if    cfg_bus ();
    twrp_char_if   char_bus ();
    twrp_result_if result_bus ();

    word_tokenizer_radix40_packer_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .chars   (char_bus),
        .results (result_bus)
    );

    tokenizer_scoreboard sb;
    int send_gap_pct;
    int stall_pct;
    int sent_chars;
    int quiet_cycles;

    always
    begin
        clk = 1'b0;
        #HalfPeriod;
        clk = 1'b1;
        #HalfPeriod;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
            result_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                sb.write_reg(cfg_bus.index, cfg_bus.data);
            if (char_bus.valid && char_bus.ready)
                sb.note_char(char_bus.character, char_bus.last_of_line);
            if (result_bus.valid && result_bus.ready)
                sb.check_result({kind_t'(result_bus.kind), result_bus.first_half,
                                 result_bus.second_half, result_bus.word_count,
                                 result_bus.last_result});
        end
    end

    always @(posedge clk)
    begin
        if ((char_bus.valid && char_bus.ready) || (result_bus.valid && result_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("[word_tokenizer_radix40_packer_core] ERROR");
            $finish;
        end
    end

    // Valid stays high across back-to-back requests; it drops only in a gap or in a drain.
    task automatic send_char(input logic [CharWidth-1:0] ch, input logic last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid        <= 1'b1;
        char_bus.character    <= ch;
        char_bus.last_of_line <= last;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        sent_chars++;
    endtask

    task automatic send_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], last_at_end && (i == s.len() - 1));
    endtask

    function automatic logic [CharWidth-1:0] pick_word_char();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return CharA + CharWidth'($urandom_range(0, 25));
        else if (sel < 90)
            return CharOne + CharWidth'($urandom_range(0, 8));
        else
            return CharHyphen;
    endfunction

    // One input line: a few commands of words, an occasional overlong
    // command, some noise bytes, and now and then a line of pure noise.
    task automatic send_random_line();
        logic [CharWidth-1:0] line_q[$];
        int ncmd;
        int nwords;
        int len;
        if ($urandom_range(99) < 6)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                line_q.push_back(CharWidth'($urandom_range(0, 255)));
        end
        else
        begin
            ncmd = $urandom_range(1, 3);
            for (int c = 0; c < ncmd; c++)
            begin
                nwords = ($urandom_range(99) < 4) ? $urandom_range(19, 23)
                                                  : $urandom_range(0, 5);
                if ($urandom_range(99) < 25)
                    line_q.push_back(CharSpace);
                for (int w = 0; w < nwords; w++)
                begin
                    if (w > 0)
                    begin
                        line_q.push_back(CharSpace);
                        if ($urandom_range(99) < 15)
                            line_q.push_back(CharSpace);
                    end
                    len = (nwords >= 19) ? $urandom_range(1, 2) : $urandom_range(1, 8);
                    for (int k = 0; k < len; k++)
                        line_q.push_back(pick_word_char());
                end
                if ($urandom_range(99) < 20)
                    line_q.push_back(CharSpace);
                if (c < ncmd - 1 || $urandom_range(1) == 1)
                    line_q.push_back($urandom_range(1) ? CharPeriod : CharComma);
            end
            for (int i = 0; i < line_q.size(); i++)
                if ($urandom_range(99) < 3)
                    line_q[i] = CharWidth'($urandom_range(0, 255));
        end
        if (line_q.size() == 0)
            line_q.push_back(CharPeriod);
        for (int i = 0; i < line_q.size(); i++)
            send_char(line_q[i], i == line_q.size() - 1);
    endtask

    task automatic write_reg(input logic [IndexWidth-1:0] idx, input logic [CharWidth-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
    endtask

    // A character that causes no token may still be in flight when the
    // last expected token arrives, so the drain then waits a settle period.
    task automatic drain();
        char_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic configure(input int phase);
        logic [CharWidth-1:0] lb;
        logic [CharWidth-1:0] db;
        logic [CharWidth-1:0] hb;
        lb = CharWidth'($urandom_range(0, 255));
        db = CharWidth'($urandom_range(0, 255));
        hb = CharWidth'($urandom_range(0, 255));
        case (phase)
            1:
            begin
                lb = 8'd0;
                db = 8'd0;
                hb = 8'd0;
            end
            2:
            begin
                lb = 8'd255;
                db = 8'd255;
                hb = 8'd255;
            end
            3:
            begin
                lb = 8'd64;
                db = 8'd48;
                hb = 8'd45;
            end
            6:
            begin
                lb = 8'd255;
                db = 8'd0;
                hb = 8'd128;
            end
            default: ;
        endcase
        write_reg(REG_LETTER_BASE, lb);
        write_reg(REG_DIGIT_BASE, db);
        write_reg(REG_HYPHEN_BASE, hb);
        if (phase == 5)
            write_reg(RegSpare, CharWidth'($urandom_range(0, 255)));
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_directed();
        send_text("AZ-19XQ .", 1'b0);
        send_text(".", 1'b0);
        send_text(" ,", 1'b0);
        send_text("K", 1'b1);
        send_text(",", 1'b1);
        // A bad character starts discarding until the end of the line.
        send_char(8'h00, 1'b0);
        send_text("A", 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("B", 1'b1);
        send_char(8'hFF, 1'b1);
        send_text("0", 1'b1);
        send_text("- 9", 1'b1);
    endtask

    initial
    begin
        sb = new();
        send_gap_pct = 0;
        stall_pct    = 0;
        sent_chars   = 0;
        rst_n                 <= 1'b0;
        char_bus.valid        <= 1'b0;
        char_bus.character    <= '0;
        char_bus.last_of_line <= 1'b0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= '0;
        cfg_bus.data          <= '0;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < PhaseCount; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1:
                begin
                    send_gap_pct = 48;
                    stall_pct    = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 48;
                end
                default:
                begin
                    send_gap_pct = 28;
                    stall_pct    = 28;
                end
            endcase
            if (phase == 0)
                run_directed();
            else
                configure(phase);
            sent_chars = 0;
            while (sent_chars < PhaseChars)
                send_random_line();
            drain();
        end
        if (sb.failures == 0 && sb.expected_q.size() == 0)
            $display("[word_tokenizer_radix40_packer_core] OK");
        else
            $display("[word_tokenizer_radix40_packer_core] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
design/twrp_pkg.sv
design/twrp_if.sv
design/twrp_front.sv
design/twrp_queue.sv
design/twrp_back.sv
design/word_tokenizer_radix40_packer_core.sv
tb/sv/tb_word_tokenizer_radix40_packer_core.sv
